/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bag table checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/ubt_pkg.sv */
// ---------------------------------------------------------------------------
// Bag table package
// Types, codes and fixed field widths shared by the bag table modules.
// ---------------------------------------------------------------------------
package ubt_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_W     = 32;
  localparam int INDEX_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_LAST,
    ST_SWAP,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  typedef enum logic [2:0] {
    RES_ADD,
    RES_NOP,
    RES_HIT,
    RES_MISS,
    RES_READ
  } res_kind_t;

  typedef enum logic [1:0] {
    RA_SCAN,
    RA_LAST,
    RA_INDEX
  } raddr_sel_t;

  typedef struct packed {
    logic       start;
    logic       scan_step;
    raddr_sel_t rsel;
    logic       load;
    res_kind_t  kind;
  } cmd_t;

  typedef struct packed {
    mode_t in_mode;
    mode_t mode;
    logic  match;
    logic  scan_over;
  } stat_t;

endpackage

/* design/ubt_datapath.sv */
// ---------------------------------------------------------------------------
// Bag table datapath
// Element memory, count, scan pointers and the result word register.
// ---------------------------------------------------------------------------
module ubt_datapath #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ubt_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [ubt_pkg::MODE_W-1:0]       in_tuser,
  input  ubt_pkg::cmd_t                    cmd,
  output ubt_pkg::stat_t                   stat,
  output logic [ubt_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CAPACITY = ubt_pkg::CAPACITY;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = ubt_pkg::VALUE_W;
  localparam int IW = ubt_pkg::INDEX_W;
  localparam int NW = ubt_pkg::COUNT_W;

  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] rdata;
  logic [AW-1:0]            raddr;

  logic [CW-1:0]            count;
  logic [ELEMENT_WIDTH-1:0] val_q;
  logic [IW-1:0]            idx_q;
  ubt_pkg::mode_t           mode_q;
  logic [CW-1:0]            scan_ptr;
  logic                     pend;
  logic [AW-1:0]            pend_ptr;

  logic [VW-1:0]            in_value;
  logic [IW-1:0]            in_idx;
  logic [CW-1:0]            last;
  logic                     issue;
  logic                     full;
  logic                     idx_ok;

  logic                     res_ok;
  logic [VW-1:0]            res_item;
  logic                     res_done;
  logic [CW-1:0]            res_count;

  assign in_value = in_tdata[VW-1:0];
  assign in_idx   = in_tdata[VW+IW-1:VW];
  assign last     = count - CW'(1);
  assign issue    = scan_ptr < count;
  assign full     = count == CW'(CAPACITY);
  assign idx_ok   = {{CW{1'b0}}, idx_q} < {{IW{1'b0}}, count};

  always_comb begin
    case (cmd.rsel)
      ubt_pkg::RA_SCAN:  raddr = scan_ptr[AW-1:0];
      ubt_pkg::RA_LAST:  raddr = last[AW-1:0];
      ubt_pkg::RA_INDEX: raddr = AW'(idx_q);
      default:           raddr = scan_ptr[AW-1:0];
    endcase
  end

  assign stat.in_mode   = ubt_pkg::mode_t'(in_tuser);
  assign stat.mode      = mode_q;
  assign stat.match     = pend && (rdata == val_q);
  assign stat.scan_over = !issue && !pend;

  always_comb begin
    res_ok    = 1'b0;
    res_item  = '0;
    res_done  = 1'b0;
    res_count = count;
    case (cmd.kind)
      ubt_pkg::RES_ADD: begin
        res_ok = !full;
        if (!full) begin
          res_count = count + CW'(1);
        end
      end
      ubt_pkg::RES_HIT: begin
        res_ok    = 1'b1;
        res_count = last;
      end
      ubt_pkg::RES_READ: begin
        res_ok   = idx_ok;
        res_done = !idx_ok;
        if (idx_ok) begin
          res_item = VW'(rdata);
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Memory: one registered read port and one write port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (cmd.load && cmd.kind == ubt_pkg::RES_ADD && !full) begin
      mem[count[AW-1:0]] <= val_q;
    end else if (cmd.load && cmd.kind == ubt_pkg::RES_HIT) begin
      mem[pend_ptr] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pend     <= 1'b0;
      scan_ptr <= '0;
    end else begin
      if (cmd.start) begin
        scan_ptr <= '0;
        pend     <= 1'b0;
      end else if (cmd.scan_step) begin
        pend <= issue;
        if (issue) begin
          scan_ptr <= scan_ptr + CW'(1);
        end
      end
      if (cmd.load) begin
        count <= res_count;
      end
    end
  end

  // The pointer of a read in flight rides along with it so a match knows its slot.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      val_q  <= ELEMENT_WIDTH'(in_value);
      idx_q  <= in_idx;
      mode_q <= ubt_pkg::mode_t'(in_tuser);
    end else if (cmd.scan_step) begin
      pend_ptr <= scan_ptr[AW-1:0];
    end
    if (cmd.load) begin
      out_tdata <= {(res_count == '0), NW'(res_count), res_done, res_item, res_ok};
    end
  end

endmodule

/* design/ubt_controller.sv */
// ---------------------------------------------------------------------------
// Bag table controller
// Sequences add, remove scan, swap and read, and owns the result word valid.
// ---------------------------------------------------------------------------
module ubt_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  ubt_pkg::stat_t stat,
  output ubt_pkg::cmd_t  cmd
);

  ubt_pkg::state_t state;
  ubt_pkg::state_t state_next;
  logic            out_valid;
  logic            out_free;

  assign out_free   = !out_valid || out_tready;
  assign out_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ubt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    in_tready     = 1'b0;
    cmd.start     = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.rsel      = ubt_pkg::RA_SCAN;
    cmd.load      = 1'b0;
    cmd.kind      = ubt_pkg::RES_NOP;
    case (state)
      ubt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          case (stat.in_mode)
            ubt_pkg::MODE_REMOVE: state_next = ubt_pkg::ST_SCAN;
            ubt_pkg::MODE_READ:   state_next = ubt_pkg::ST_RD_ADDR;
            default:              state_next = ubt_pkg::ST_EXEC;
          endcase
        end
      end
      ubt_pkg::ST_EXEC: begin
        cmd.kind = (stat.mode == ubt_pkg::MODE_ADD) ? ubt_pkg::RES_ADD : ubt_pkg::RES_NOP;
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ubt_pkg::ST_IDLE;
        end
      end
      ubt_pkg::ST_SCAN: begin
        cmd.rsel      = ubt_pkg::RA_SCAN;
        cmd.scan_step = 1'b1;
        cmd.kind      = ubt_pkg::RES_MISS;
        if (stat.match) begin
          cmd.scan_step = 1'b0;
          state_next    = ubt_pkg::ST_LAST;
        end else if (stat.scan_over && out_free) begin
          cmd.load   = 1'b1;
          state_next = ubt_pkg::ST_IDLE;
        end
      end
      ubt_pkg::ST_LAST: begin
        cmd.rsel   = ubt_pkg::RA_LAST;
        state_next = ubt_pkg::ST_SWAP;
      end
      ubt_pkg::ST_SWAP: begin
        cmd.rsel = ubt_pkg::RA_LAST;
        cmd.kind = ubt_pkg::RES_HIT;
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ubt_pkg::ST_IDLE;
        end
      end
      ubt_pkg::ST_RD_ADDR: begin
        cmd.rsel   = ubt_pkg::RA_INDEX;
        state_next = ubt_pkg::ST_RD_DATA;
      end
      ubt_pkg::ST_RD_DATA: begin
        cmd.rsel = ubt_pkg::RA_INDEX;
        cmd.kind = ubt_pkg::RES_READ;
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = ubt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ubt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/unordered_bag_table_core.sv */
// ---------------------------------------------------------------------------
// Unordered bag table core
// Multiset of values with add, swap-remove and indexed read.
// ---------------------------------------------------------------------------
// The s_axis channel takes one operation word: tuser carries the mode (add,
// remove, read, or no operation), tdata the value and the read index. The
// m_axis channel returns exactly one result word per operation, carrying
// the ok flag, the read item, the done flag, the count and the empty flag.
// Read first addresses the element memory, then takes its registered read
// data. Remove scans the memory one entry per cycle through the single
// read port; on a hit at slot p the last entry is read and written into
// slot p. One operation is in flight at a time; the next word is taken
// once the controller is back in its idle state, even while the last
// result word still waits in the output register. When m_axis is stalled
// the result word holds and the block waits before loading the next one.
// Reset empties the table (count zero) and drops any pending result word;
// the element memory itself is not cleared.
module unordered_bag_table_core #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata fields, low bit up: value[31:0], read_index[35:32], zero pad.
  input  logic [ubt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser fields, low bit up: mode[1:0].
  input  logic [ubt_pkg::MODE_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata fields, low bit up: ok[0], item[32:1], done_res[33], count[38:34],
  // empty_res[39].
  output logic [ubt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  ubt_pkg::cmd_t  cmd;
  ubt_pkg::stat_t stat;

  ubt_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  ubt_datapath #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_tdata  (s_axis_tdata),
    .in_tuser  (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (m_axis_tdata)
  );

endmodule

/* design/ubt_checker.sv */
// ---------------------------------------------------------------------------
// Bag table port checker
// Checks result words seen on the ports of the bag table core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ubt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ubt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       res_ok;
  logic       res_done;
  logic       res_empty;
  logic [4:0] res_count;
  logic [31:0] res_item;

  assign res_ok    = m_axis_tdata[0];
  assign res_item  = m_axis_tdata[32:1];
  assign res_done  = m_axis_tdata[33];
  assign res_count = m_axis_tdata[38:34];
  assign res_empty = m_axis_tdata[39];

  // A stalled result word stays put.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // The empty flag tracks the reported count.
  `ASSERT_SAME(a_empty_count, clk, rst, m_axis_tvalid, res_empty == (res_count == 5'd0))

  // A read either succeeds or reports the end, never both.
  `ASSERT_SAME(a_ok_done, clk, rst, m_axis_tvalid, !(res_ok && res_done))

  // A failed operation carries no item.
  `ASSERT_SAME(a_item_zero, clk, rst, m_axis_tvalid && !res_ok, res_item == 32'd0)

  // Only one operation is taken at a time.
  `ASSERT_NEXT(a_in_single, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind unordered_bag_table_core ubt_checker u_chk (.*);
